/* hdl/box_downscale_3x3_rgb_macros.svh */
// Assertion macros used by the box downscaler checker.
`ifndef BOX_DOWNSCALE_3X3_RGB_MACROS_SVH
`define BOX_DOWNSCALE_3X3_RGB_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication on top of BDS_ASSERT.
`define BDS_ASSERT_IMP(lbl, ante, cons, msg) \
  `BDS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* hdl/bds_pkg.sv */
// Package: widths, constants, types and helpers of the 3x3 box downscaler.
package bds_pkg;

  localparam int unsigned MaxOutWidth = 1024;
  localparam int unsigned AddrW       = $clog2(MaxOutWidth);
  localparam int unsigned OutWW       = $clog2(MaxOutWidth + 1);
  localparam int unsigned PixW        = 8;
  localparam int unsigned PosW        = 12;
  localparam int unsigned HsumW       = 10;
  localparam int unsigned LsumW       = 12;
  localparam int unsigned LineW       = 3 * LsumW;

  localparam logic [PosW-1:0] FrameWidthRst  = 12'd1920;
  localparam logic [PosW-1:0] FrameHeightRst = 12'd1080;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_MID   = 2'd1,
    PH_LAST  = 2'd2
  } phase_e;

  typedef struct packed {
    logic             active;
    phase_e           op;
    logic [AddrW-1:0] idx;
    logic             eor;
    logic             eof;
  } s1_ctl_t;

  function automatic phase_e ph_next(phase_e ph);
    phase_e r;
    case (ph)
      PH_FIRST: r = PH_MID;
      PH_MID:   r = PH_LAST;
      default:  r = PH_FIRST;
    endcase
    return r;
  endfunction

  // floor(x / 3) for x < 4096
  function automatic logic [PosW-2:0] div3(logic [PosW-1:0] x);
    logic [23:0] p;
    p = {12'd0, x} * 24'd2731;
    return p[23:13];
  endfunction

  // floor(x / 9) mod 256 for x < 4100
  function automatic logic [PixW-1:0] div9(logic [12:0] x);
    logic [25:0] p;
    p = {13'd0, x} * 26'd7282;
    return p[23:16];
  endfunction

endpackage

/* hdl/bds_pix_if.sv */
// Interfaces: input pixel channel and result channel.
interface bds_pix_if import bds_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] in_blue;
  logic [PixW-1:0] in_green;
  logic [PixW-1:0] in_red;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  input ready);
  modport sink   (input valid, input in_blue, input in_green, input in_red,
                  output ready);
endinterface

interface bds_res_if import bds_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] avg_blue;
  logic [PixW-1:0] avg_green;
  logic [PixW-1:0] avg_red;
  logic            end_of_out_row;
  logic            end_of_out_frame;

  modport source (output valid, output avg_blue, output avg_green, output avg_red,
                  output end_of_out_row, output end_of_out_frame, input ready);
  modport sink   (input valid, input avg_blue, input avg_green, input avg_red,
                  input end_of_out_row, input end_of_out_frame, output ready);
endinterface

/* hdl/box_downscale_3x3_rgb.sv */
// Top level: 3x3 box-filter decimation of an RGB pixel stream.
//
// pix_in takes one RGB pixel word per accepted handshake, raster order.
// pix_out gives one word per full 3x3 block: the rounded channel means plus
// end-of-row and end-of-frame marks. Partial blocks at the right and bottom
// edges are consumed without a result.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i set frame width and height;
// write only while the block is idle.
// Throughput: one pixel per cycle while pix_out does not stall. After the last
// pixel of its block is accepted, a result word passes through the input stage
// (with the line store read) and then the output register.
// The line store (one entry per output column) is a single-port-write,
// single-read RAM; its registered read sets the input stage.
// Reset clears positions, horizontal sums and both stages; the line store is
// not cleared, since every entry is written on the first row of a block row.
// When pix_out stalls, the output register holds its word, the input stage
// holds one more, and pix_in.ready drops only once both are full.
module box_downscale_3x3_rgb import bds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  bds_pix_if.sink         pix_in,
  bds_res_if.source       pix_out,
  input  logic            cfg_we_i,
  input  cfg_idx_e        cfg_idx_i,
  input  logic [PosW-1:0] cfg_data_i
);

  logic [PosW-1:0]  fw_q, fh_q;
  logic [PosW-1:0]  col_q, col_d, row_q, row_d;
  logic [PosW-1:0]  bc_q, bc_d, br_q, br_d;
  phase_e           cph_q, cph_d, rph_q, rph_d;
  logic [HsumW-1:0] hb_q, hg_q, hr_q, hb_d, hg_d, hr_d;

  logic             s1_valid_q;
  s1_ctl_t          s1_ctl_q, s1_ctl_d;
  logic [LineW-1:0] rd_q, byp_data_q, rd_data;
  logic             byp_q;
  logic [LineW-1:0] mem [MaxOutWidth];
  logic [LineW-1:0] wdata;
  logic             mem_we;

  logic             out_valid_q;
  logic [PixW-1:0]  ob_q, og_q, or_q;
  logic             eor_q, eof_q;

  logic             acc, s1_adv, col_last, row_last;
  logic [OutWW-1:0] out_w;
  logic [PosW-2:0]  out_w_raw, out_h;
  logic [LsumW-1:0] sb, sg, sr;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FrameWidthRst;
      fh_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
      endcase
    end
  end

  assign out_w_raw = div3(fw_q);
  assign out_h     = div3(fh_q);
  assign out_w = ({2'd0, out_w_raw} > OutWW'(MaxOutWidth)) ? OutWW'(MaxOutWidth)
                                                           : OutWW'(out_w_raw);

  // Handshake
  assign s1_adv       = s1_valid_q && (!out_valid_q || pix_out.ready);
  assign pix_in.ready = !s1_valid_q || s1_adv;
  assign acc          = pix_in.valid && pix_in.ready;

  // Position tracking and horizontal sums
  assign col_last = ({1'b0, col_q} + 13'd1) >= {1'b0, fw_q};
  assign row_last = ({1'b0, row_q} + 13'd1) >= {1'b0, fh_q};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    bc_d  = bc_q;
    br_d  = br_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (col_last) begin
      col_d = '0;
      bc_d  = '0;
      cph_d = PH_FIRST;
      if (row_last) begin
        row_d = '0;
        br_d  = '0;
        rph_d = PH_FIRST;
      end else begin
        row_d = row_q + 12'd1;
        rph_d = ph_next(rph_q);
        if (rph_q == PH_LAST) begin
          br_d = br_q + 12'd1;
        end
      end
    end else begin
      col_d = col_q + 12'd1;
      cph_d = ph_next(cph_q);
      if (cph_q == PH_LAST) begin
        bc_d = bc_q + 12'd1;
      end
    end
  end

  always_comb begin
    if (cph_q == PH_FIRST) begin
      hb_d = {2'd0, pix_in.in_blue};
      hg_d = {2'd0, pix_in.in_green};
      hr_d = {2'd0, pix_in.in_red};
    end else begin
      hb_d = hb_q + {2'd0, pix_in.in_blue};
      hg_d = hg_q + {2'd0, pix_in.in_green};
      hr_d = hr_q + {2'd0, pix_in.in_red};
    end
  end

  always_comb begin
    s1_ctl_d.active = (cph_q == PH_LAST) && ({1'b0, bc_q} < OutWW'(out_w))
                      && (br_q < {1'b0, out_h});
    s1_ctl_d.op     = rph_q;
    s1_ctl_d.idx    = bc_q[AddrW-1:0];
    s1_ctl_d.eor    = (OutWW'({1'b0, bc_q} + 13'd1) == out_w);
    s1_ctl_d.eof    = s1_ctl_d.eor && (({1'b0, br_q} + 13'd1) == {2'd0, out_h});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      bc_q  <= '0;
      br_q  <= '0;
      cph_q <= PH_FIRST;
      rph_q <= PH_FIRST;
      hb_q  <= '0;
      hg_q  <= '0;
      hr_q  <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
      bc_q  <= bc_d;
      br_q  <= br_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
      hb_q  <= hb_d;
      hg_q  <= hg_d;
      hr_q  <= hr_d;
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  // Line store: {red, green, blue} partial block sums per output column
  assign rd_data = byp_q ? byp_data_q : rd_q;
  assign sb = rd_data[LsumW-1:0]         + {2'd0, hb_q};
  assign sg = rd_data[2*LsumW-1:LsumW]   + {2'd0, hg_q};
  assign sr = rd_data[3*LsumW-1:2*LsumW] + {2'd0, hr_q};

  assign mem_we = s1_adv && s1_ctl_q.active && (s1_ctl_q.op != PH_LAST);
  assign wdata  = (s1_ctl_q.op == PH_FIRST) ? {2'd0, hr_q, 2'd0, hg_q, 2'd0, hb_q}
                                            : {sr, sg, sb};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_ctl_q.idx] <= wdata;
    end
    if (acc) begin
      rd_q       <= mem[bc_q[AddrW-1:0]];
      byp_q      <= mem_we && (s1_ctl_q.idx == bc_q[AddrW-1:0]);
      byp_data_q <= wdata;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_ctl_q.active && (s1_ctl_q.op == PH_LAST);
    end else if (pix_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ob_q  <= div9({1'b0, sb} + 13'd4);
      og_q  <= div9({1'b0, sg} + 13'd4);
      or_q  <= div9({1'b0, sr} + 13'd4);
      eor_q <= s1_ctl_q.eor;
      eof_q <= s1_ctl_q.eof;
    end
  end

  assign pix_out.valid            = out_valid_q;
  assign pix_out.avg_blue         = ob_q;
  assign pix_out.avg_green        = og_q;
  assign pix_out.avg_red          = or_q;
  assign pix_out.end_of_out_row   = eor_q;
  assign pix_out.end_of_out_frame = eof_q;

endmodule

/* hdl/bds_checker.sv */
// Checker on the downscaler ports, bound to the top level.
`include "box_downscale_3x3_rgb_macros.svh"

module bds_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_eor_i,
  input logic out_eof_i
);

  `BDS_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> out_valid_i, "result word dropped while stalled")
  `BDS_ASSERT_IMP(a_eof_eor, out_valid_i && out_eof_i, out_eor_i, "frame end without row end")
  `BDS_ASSERT_IMP(a_out_cause, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result word without input word two cycles before")
  `BDS_ASSERT_IMP(a_ready_free, !out_valid_i, in_ready_i, "input stalled while output register empty")

endmodule

bind box_downscale_3x3_rgb bds_checker u_bds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in.valid),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (pix_out.valid),
  .out_ready_i (pix_out.ready),
  .out_eor_i   (pix_out.end_of_out_row),
  .out_eof_i   (pix_out.end_of_out_frame)
);

/* bench/box_downscale_3x3_rgb_tb.sv */
`timescale 1ns / 100ps
// Testbench of the 3x3 box downscaler: predicts each block average and checks the result words.
module box_downscale_3x3_rgb_tb;
  import bds_pkg::*;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
    logic            eor;
    logic            eof;
  } block_avg_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  cfg_idx_e        cfg_idx_i;
  logic [PosW-1:0] cfg_data_i;

  bds_pix_if pix_in_if ();
  bds_res_if pix_out_if ();

  box_downscale_3x3_rgb dut (
    .clk_i,
    .rst_ni,
    .pix_in     (pix_in_if),
    .pix_out    (pix_out_if),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // predicted block state
  logic [LsumW-1:0] part_sums [MaxOutWidth][3];
  logic [HsumW-1:0] row_sums [3];
  logic [PosW-1:0]  col_pos;
  logic [PosW-1:0]  row_pos;
  logic [PosW-1:0]  width_reg;
  logic [PosW-1:0]  height_reg;

  block_avg_t  pending_avgs [$];
  int unsigned n_pixels;
  int unsigned n_avgs;
  int unsigned n_errors;
  int unsigned n_settings;
  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void downscale_pixel(input rgb_t px);
    logic [PixW-1:0]  chan [3];
    logic [LsumW-1:0] blk;
    block_avg_t       avg;
    int unsigned      out_w, out_h, bc, br, cph, rph;
    int               c;
    chan[0] = px.blue;
    chan[1] = px.green;
    chan[2] = px.red;
    out_w = width_reg / 3;
    if (out_w > MaxOutWidth) out_w = MaxOutWidth;
    out_h = height_reg / 3;
    bc  = col_pos / 3;
    br  = row_pos / 3;
    cph = col_pos % 3;
    rph = row_pos % 3;
    for (c = 0; c < 3; c++) row_sums[c] = (cph == 0) ? chan[c] : row_sums[c] + chan[c];
    if (cph == 2 && bc < out_w && br < out_h) begin
      case (rph)
        0: for (c = 0; c < 3; c++) part_sums[bc][c] = row_sums[c];
        1: for (c = 0; c < 3; c++) part_sums[bc][c] = part_sums[bc][c] + row_sums[c];
        default: begin
          for (c = 0; c < 3; c++) begin
            blk = part_sums[bc][c] + row_sums[c];
            chan[c] = PixW'((blk + 4) / 9);
          end
          avg.blue  = chan[0];
          avg.green = chan[1];
          avg.red   = chan[2];
          avg.eor   = (bc + 1 == out_w);
          avg.eof   = (bc + 1 == out_w) && (br + 1 == out_h);
          pending_avgs.push_back(avg);
        end
      endcase
    end
    if (col_pos + 1 >= width_reg) begin
      col_pos = '0;
      row_pos = (row_pos + 1 >= height_reg) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PixW-1:0] rand_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PixW'($urandom_range(0, 255));
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t px;
    px.blue  = rand_level();
    px.green = rand_level();
    px.red   = rand_level();
    return px;
  endfunction

  function automatic void check_field(input string field, input logic [PixW-1:0] want,
                                      input logic [PixW-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= 40)
        $display("%t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    block_avg_t want;
    if (rst_ni && pix_out_if.valid && pix_out_if.ready) begin
      if (pending_avgs.size() == 0) begin
        n_errors++;
        if (n_errors <= 40)
          $display("%t: unexpected word, expected none, actual b=%0d g=%0d r=%0d", $time,
                   pix_out_if.avg_blue, pix_out_if.avg_green, pix_out_if.avg_red);
      end else begin
        want = pending_avgs.pop_front();
        n_avgs++;
        check_field("avg_blue", want.blue, pix_out_if.avg_blue);
        check_field("avg_green", want.green, pix_out_if.avg_green);
        check_field("avg_red", want.red, pix_out_if.avg_red);
        check_field("end_of_out_row", PixW'(want.eor), PixW'(pix_out_if.end_of_out_row));
        check_field("end_of_out_frame", PixW'(want.eof), PixW'(pix_out_if.end_of_out_frame));
      end
    end
  end

  initial begin
    int unsigned n;
    pix_out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      pix_out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
      n = pick_gap(sink_stalls_on);
      if (n != 0) begin
        pix_out_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
    end
  end

  task automatic send_pixel(input rgb_t px);
    int unsigned gap;
    gap = pick_gap(src_gaps_on);
    if (gap != 0) begin
      pix_in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_in_if.valid    <= 1'b1;
    pix_in_if.in_blue  <= px.blue;
    pix_in_if.in_green <= px.green;
    pix_in_if.in_red   <= px.red;
    @(posedge clk_i);
    while (!pix_in_if.ready) @(posedge clk_i);
    downscale_pixel(px);
    n_pixels++;
    @(negedge clk_i);
  endtask

  task automatic send_pixels(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  // runs until the raster position wraps back to the frame origin
  task automatic send_frame();
    do send_pixel(rand_pixel()); while (col_pos != '0 || row_pos != '0);
  endtask

  task automatic wait_drained();
    pix_in_if.valid <= 1'b0;
    while (pending_avgs.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [PosW-1:0] w, input logic [PosW-1:0] h);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg  = w;
    height_reg = h;
    n_settings++;
    @(negedge clk_i);
  endtask

  task automatic test_block_means();
    rgb_t px;
    int   i;
    set_frame(3, 3);
    for (i = 0; i < 9; i++) begin
      px.blue  = '1;
      px.green = '0;
      px.red   = (i == 0) ? 8'd5 : 8'd0;
      send_pixel(px);
    end
    for (i = 0; i < 9; i++) begin
      px.blue  = (i == 8) ? 8'd4 : 8'd0;
      px.green = 8'd128;
      px.red   = (i == 4) ? 8'd104 : 8'd100;
      send_pixel(px);
    end
  endtask

  task automatic test_partial_blocks();
    int unsigned ws [5] = '{4, 5, 8, 6, 11};
    int unsigned hs [5] = '{4, 5, 7, 3, 8};
    int          i;
    for (i = 0; i < 5; i++) begin
      set_frame(ws[i], hs[i]);
      send_frame();
    end
  endtask

  task automatic test_tiny_frames();
    int unsigned ws [11] = '{0, 1, 1, 2, 2, 0, 5, 2, 7, 3, 2};
    int unsigned hs [11] = '{0, 1, 2, 1, 2, 5, 0, 7, 2, 2, 3};
    int          i;
    for (i = 0; i < 11; i++) begin
      set_frame(ws[i], hs[i]);
      send_frame();
    end
  endtask

  // size changes land on block-row boundaries so every store read follows a write
  task automatic test_mid_frame_change();
    set_frame(9, 9);
    send_pixels(27);
    set_frame(6, 6);
    send_frame();
    set_frame(12, 12);
    send_pixels(36);
    set_frame(12, 3);
    send_frame();
    set_frame(15, 9);
    send_pixels(45);
    set_frame(9, 9);
    send_frame();
    set_frame(6, 9);
    send_pixels(18);
    set_frame(15, 9);
    send_frame();
  endtask

  task automatic test_random_frames();
    int unsigned target, w, h, frames;
    target = 1150;
    frames = 0;
    while (n_pixels < target) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 60) : $urandom_range(3, 30);
      h = $urandom_range(3, 10);
      set_frame(w, h);
      src_gaps_on    = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      if (frames == 2) begin
        send_pixels(w * h / 2);
        wait_drained();
      end
      send_frame();
      if ($urandom_range(0, 2) == 0) send_frame();
      frames++;
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_FRAME_WIDTH;
    cfg_data_i          = '0;
    pix_in_if.valid     = 1'b0;
    pix_in_if.in_blue   = '0;
    pix_in_if.in_green  = '0;
    pix_in_if.in_red    = '0;
    width_reg           = FrameWidthRst;
    height_reg          = FrameHeightRst;
    col_pos             = '0;
    row_pos             = '0;
    row_sums            = '{default: '0};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_block_means();
    test_partial_blocks();
    test_tiny_frames();
    test_mid_frame_change();
    test_random_frames();

    wait_drained();
    repeat (10) @(negedge clk_i);
    $display("Sent %0d pixels under %0d frame size settings, checked %0d block averages.",
             n_pixels, n_settings, n_avgs);
    $display("Sizes ran from empty and partial-block frames through resizes on block rows.");
    if (n_errors == 0 && pending_avgs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* box_downscale_3x3_rgb.f */
+incdir+hdl
hdl/bds_pkg.sv
hdl/bds_pix_if.sv
hdl/box_downscale_3x3_rgb.sv
hdl/bds_checker.sv
bench/box_downscale_3x3_rgb_tb.sv
